// File: rtl/rke_pkg.sv
`default_nettype none

package rke_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int RADIX_W    = 3;
   localparam int KLEN_W     = 4;
   localparam int DIGIT_W    = 3;
   localparam int IDX_W      = 21;
   localparam int TOP_W      = 19;
   localparam int STATUS_W   = 2;
   localparam int OUT_DATA_W = 24;

   localparam int MAX_KMER  = 9;
   localparam int RADIX_N   = 2 ** RADIX_W;

   // remainder arithmetic works on radix-8 digits of the window index
   localparam int REM_BITS   = 3;
   localparam int REM_DIGITS = IDX_W / REM_BITS;
   localparam int REM_CNT_W  = $clog2(REM_DIGITS);
   localparam int WIDE_W     = TOP_W + REM_BITS;
   localparam int MULT_N     = 2 ** REM_BITS - 1;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [RADIX_W-1:0] ALPHABET_RESET = RADIX_W'(4);
   localparam logic [KLEN_W-1:0]  KMER_RESET     = KLEN_W'(5);

   // front to back queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_BASE = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_ALPHABET = 1'b0,
      REG_KMER     = 1'b1
   } csr_reg_type;

   // multiples 1..7 of the top digit weight
   typedef logic [MULT_N:1][WIDE_W-1:0] mult_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [KLEN_W-1:0]  keff;
      logic [TOP_W-1:0]   top;
      mult_type           mults;
      logic               wr;
   } cfg_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               bad;
      logic               read_start;
      logic               read_end;
   } item_type;

   // radix to the power of (k - 1), kept to 19 bits; rows by radix, columns by k - 1
   localparam logic [TOP_W-1:0] TOP_WEIGHT [RADIX_N][MAX_KMER] = '{
      '{19'd1, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0},
      '{19'd1, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1},
      '{19'd1, 19'd2, 19'd4, 19'd8, 19'd16, 19'd32, 19'd64, 19'd128, 19'd256},
      '{19'd1, 19'd3, 19'd9, 19'd27, 19'd81, 19'd243, 19'd729, 19'd2187, 19'd6561},
      '{19'd1, 19'd4, 19'd16, 19'd64, 19'd256, 19'd1024, 19'd4096, 19'd16384,
        19'd65536},
      '{19'd1, 19'd5, 19'd25, 19'd125, 19'd625, 19'd3125, 19'd15625, 19'd78125,
        19'd390625},
      '{19'd1, 19'd6, 19'd36, 19'd216, 19'd1296, 19'd7776, 19'd46656, 19'd279936,
        19'd106752},
      '{19'd1, 19'd7, 19'd49, 19'd343, 19'd2401, 19'd16807, 19'd117649, 19'd299255,
        19'd521921}
   };

endpackage

`default_nettype wire

// File: rtl/rke_csr.sv
`default_nettype none

module rke_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rke_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rke_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rke_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output rke_pkg::cfg_type                  cfg
);
   import rke_pkg::*;

   logic [RADIX_W-1:0] alphabet_ff, alphabet_in;
   logic [KLEN_W-1:0]  kmer_ff, kmer_in;
   logic [KLEN_W-1:0]  keff_ff, keff_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   mult_type           mult_ff, mult_in;
   logic               wr_en;
   csr_reg_type        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      alphabet_in = alphabet_ff;
      kmer_in     = kmer_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ALPHABET: alphabet_in = csr_pwdata[RADIX_W-1:0];
            REG_KMER:     kmer_in     = csr_pwdata[KLEN_W-1:0];
            default:      alphabet_in = alphabet_ff;
         endcase
      end
      if (reset) begin
         alphabet_in = ALPHABET_RESET;
         kmer_in     = KMER_RESET;
      end
   end

   // clamp k to 1..MAX_KMER, then look up the weight and its multiples
   always_comb begin
      if (kmer_in == '0) begin
         keff_in = KLEN_W'(1);
      end else if (kmer_in > KLEN_W'(MAX_KMER)) begin
         keff_in = KLEN_W'(MAX_KMER);
      end else begin
         keff_in = kmer_in;
      end
      top_in = TOP_WEIGHT[alphabet_in][keff_in - KLEN_W'(1)];
      for (int m = 1; m <= MULT_N; m++) begin
         mult_in[m] = WIDE_W'(top_in) * WIDE_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      alphabet_ff <= alphabet_in;
      kmer_ff     <= kmer_in;
      keff_ff     <= keff_in;
      top_ff      <= top_in;
      mult_ff     <= mult_in;
   end

   always_comb begin
      unique case (reg_sel)
         REG_ALPHABET: csr_prdata = CSR_DATA_W'(alphabet_ff);
         REG_KMER:     csr_prdata = CSR_DATA_W'(kmer_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.radix = alphabet_ff;
   assign cfg.keff  = keff_ff;
   assign cfg.top   = top_ff;
   assign cfg.mults = mult_ff;
   assign cfg.wr    = wr_en;

endmodule

`default_nettype wire

// File: rtl/rke_front.sv
`default_nettype none

module rke_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rke_pkg::CHAR_W-1:0]    req_tdata,
   input  logic                          req_tuser,
   input  logic                          req_tlast,
   input  logic [rke_pkg::RADIX_W-1:0]   radix,
   output logic                          push_valid,
   output rke_pkg::item_type             push_item,
   input  logic                          push_ready
);
   import rke_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_U_UP = 8'h55;
   localparam logic [CHAR_W-1:0] CHAR_U_LO = 8'h75;
   localparam logic [CHAR_W-1:0] CHAR_N_UP = 8'h4E;
   localparam logic [CHAR_W-1:0] CHAR_N_LO = 8'h6E;

   // {is_base, digit}
   function automatic logic [DIGIT_W:0] char_digit(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W:0] r;
      case (c) inside
         CHAR_A_UP, CHAR_A_LO:                       r = {1'b1, DIGIT_W'(0)};
         CHAR_C_UP, CHAR_C_LO:                       r = {1'b1, DIGIT_W'(1)};
         CHAR_G_UP, CHAR_G_LO:                       r = {1'b1, DIGIT_W'(2)};
         CHAR_T_UP, CHAR_T_LO, CHAR_U_UP, CHAR_U_LO: r = {1'b1, DIGIT_W'(3)};
         CHAR_N_UP, CHAR_N_LO:                       r = {1'b1, DIGIT_W'(4)};
         default:                                    r = '0;
      endcase
      return r;
   endfunction

   logic [DIGIT_W:0] coded;

   assign coded = char_digit(req_tdata);

   always_comb begin
      push_item.digit      = coded[DIGIT_W-1:0];
      push_item.bad        = !coded[DIGIT_W] || (coded[DIGIT_W-1:0] >= radix);
      push_item.read_start = req_tuser;
      push_item.read_end   = req_tlast;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

`default_nettype wire

// File: rtl/rke_queue.sv
`default_nettype none

module rke_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  rke_pkg::item_type    push_item,
   output logic                 push_ready,
   output logic                 pop_valid,
   output rke_pkg::item_type    pop_item,
   input  logic                 pop_ready
);
   import rke_pkg::*;

   localparam int CNT_W = QUEUE_AW + 1;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rke_back.sv
`default_nettype none

module rke_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rke_pkg::cfg_type                  cfg,
   input  logic                              pop_valid,
   input  rke_pkg::item_type                 pop_item,
   output logic                              pop_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rke_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic [rke_pkg::STATUS_W-1:0]      rsp_tuser
);
   import rke_pkg::*;

   localparam int PROD_W = IDX_W + RADIX_W;

   // x is below eight times the weight; strip the largest multiple that fits
   function automatic logic [TOP_W-1:0] reduce_mod(input logic [WIDE_W-1:0] x,
                                                   input mult_type mults);
      logic [WIDE_W-1:0] sub;
      sub = '0;
      for (int m = 1; m <= MULT_N; m++) begin
         if (x >= mults[m]) begin
            sub = mults[m];
         end
      end
      return TOP_W'(x - sub);
   endfunction

   // read state
   logic [IDX_W-1:0]  w_ff, w_in;
   logic [KLEN_W-1:0] bs_ff, bs_in;
   logic              drop_ff, drop_in;
   // window index modulo the top weight
   logic [TOP_W-1:0]  r_ff, r_in;
   logic              r_valid_ff, r_valid_in;
   // remainder unit
   logic                 rem_busy_ff, rem_busy_in;
   logic [REM_CNT_W-1:0] rem_cnt_ff, rem_cnt_in;
   logic [TOP_W-1:0]     rem_p_ff, rem_p_in;
   logic [IDX_W-1:0]     rem_src_ff, rem_src_in;
   logic [TOP_W-1:0]     rem_step;
   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]  eff_w, base, w_new;
   logic [KLEN_W-1:0] eff_bs, bs_new;
   logic              eff_drop, full_now, use_r, full_after, fast_ok;
   logic [PROD_W-1:0] prod;
   logic              has_out, wait_r, do_pop, top_zero;
   logic [IDX_W-1:0]  out_index;
   status_type        out_status;
   logic [IDX_W-1:0]  st_w;
   logic [KLEN_W-1:0] st_bs;
   logic              st_drop, r_touch, st_rv;
   logic [TOP_W-1:0]  st_r;

   assign top_zero = cfg.top == '0;

   // datapath for the item at the head of the queue
   always_comb begin
      eff_w    = pop_item.read_start ? '0 : w_ff;
      eff_bs   = pop_item.read_start ? '0 : bs_ff;
      eff_drop = pop_item.read_start ? 1'b0 : drop_ff;
      full_now = eff_bs >= cfg.keff;
      use_r    = full_now && !top_zero;
      base     = use_r ? IDX_W'(r_ff) : eff_w;
      prod     = PROD_W'(base) * PROD_W'(cfg.radix) + PROD_W'(pop_item.digit);
      w_new    = prod[IDX_W-1:0];
      bs_new   = full_now ? eff_bs : eff_bs + KLEN_W'(1);
      full_after = bs_new >= cfg.keff;
      fast_ok  = !top_zero && (TOP_W'(w_new[IDX_W-1:REM_BITS]) < cfg.top);

      has_out    = 1'b0;
      out_index  = '0;
      out_status = STATUS_OK;
      st_w       = eff_w;
      st_bs      = eff_bs;
      st_drop    = eff_drop;
      r_touch    = pop_item.read_start;
      st_r       = '0;
      st_rv      = 1'b1;

      if (!eff_drop) begin
         if (pop_item.bad) begin
            has_out    = 1'b1;
            out_status = STATUS_BAD_BASE;
            st_drop    = 1'b1;
         end else begin
            st_w    = w_new;
            st_bs   = bs_new;
            r_touch = 1'b1;
            st_r    = reduce_mod(WIDE_W'(w_new), cfg.mults);
            st_rv   = fast_ok;
            if (full_after) begin
               has_out   = 1'b1;
               out_index = w_new;
            end else if (pop_item.read_end) begin
               has_out    = 1'b1;
               out_status = STATUS_SHORT;
            end
         end
      end

      if (pop_item.read_end) begin
         st_w    = '0;
         st_bs   = '0;
         st_drop = 1'b0;
         r_touch = 1'b1;
         st_r    = '0;
         st_rv   = 1'b1;
      end

      wait_r    = !eff_drop && !pop_item.bad && use_r && !r_valid_ff;
      pop_ready = !wait_r && (!has_out || !rsp_valid_ff || rsp_tready);
      do_pop    = pop_valid && pop_ready;
   end

   assign rem_step = reduce_mod({rem_p_ff, rem_src_ff[IDX_W-1 -: REM_BITS]}, cfg.mults);

   // state update, remainder unit and result register
   always_comb begin
      w_in    = w_ff;
      bs_in   = bs_ff;
      drop_in = drop_ff;
      r_in        = r_ff;
      r_valid_in  = r_valid_ff;
      rem_busy_in = rem_busy_ff;
      rem_cnt_in  = rem_cnt_ff;
      rem_p_in    = rem_p_ff;
      rem_src_in  = rem_src_ff;

      if (rem_busy_ff) begin
         rem_p_in   = rem_step;
         rem_src_in = rem_src_ff << REM_BITS;
         rem_cnt_in = rem_cnt_ff + REM_CNT_W'(1);
         if (rem_cnt_ff == REM_CNT_W'(REM_DIGITS - 1)) begin
            r_in        = rem_step;
            r_valid_in  = 1'b1;
            rem_busy_in = 1'b0;
         end
      end else if (!r_valid_ff && !top_zero) begin
         rem_busy_in = 1'b1;
         rem_cnt_in  = '0;
         rem_p_in    = '0;
         rem_src_in  = w_ff;
      end

      if (do_pop) begin
         w_in    = st_w;
         bs_in   = st_bs;
         drop_in = st_drop;
         if (r_touch) begin
            r_in        = st_r;
            r_valid_in  = st_rv;
            rem_busy_in = 1'b0;
         end
      end

      // new weight after a register write
      if (cfg.wr) begin
         r_valid_in  = 1'b0;
         rem_busy_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      if (do_pop && has_out) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = out_index;
         rsp_status_in = out_status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= '0;
         bs_ff        <= '0;
         drop_ff      <= 1'b0;
         r_ff         <= '0;
         r_valid_ff   <= 1'b1;
         rem_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff         <= w_in;
         bs_ff        <= bs_in;
         drop_ff      <= drop_in;
         r_ff         <= r_in;
         r_valid_ff   <= r_valid_in;
         rem_busy_ff  <= rem_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_cnt_ff    <= rem_cnt_in;
      rem_p_ff      <= rem_p_in;
      rem_src_ff    <= rem_src_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'(rsp_index_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/rolling_kmer_index_encoder.sv
`default_nettype none

// channel   | ports     | word
// ----------+-----------+---------------------------------------------------
// req (in)  | req_t*    | tdata base_char, tuser read_start, tlast read_end
// rsp (out) | rsp_t*    | tdata kmer_index (zero padded), tuser status
// csr       | csr_p*    | alphabet_size at 0x0, kmer_length at 0x4
//
// one base per cycle while nothing stalls; a result goes from the queue slot
// written as its base is taken, through the back stage, to the result register
// synchronous reset; leaves alphabet 4, k 5 and an empty window
// window mod weight is kept current with each update; after a register write,
// or a window at eight times the weight or more, a remainder pass runs
// and a base that needs it waits; a full result register stalls only result bases

module rolling_kmer_index_encoder (
   input  logic                              clock,
   input  logic                              reset,
   // base stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rke_pkg::CHAR_W-1:0]        req_tdata,   // [7:0] base_char
   input  logic                              req_tuser,   // [0] read_start
   input  logic                              req_tlast,
   // k-mer index stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rke_pkg::OUT_DATA_W-1:0]    rsp_tdata,   // [20:0] kmer_index
   output logic [rke_pkg::STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rke_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rke_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rke_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rke_pkg::*;

   cfg_type  cfg;
   // front side of the queue: classified bases
   logic     push_valid, push_ready;
   item_type push_item;
   // back side of the queue
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // registers, top digit weight and its multiples
   rke_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // character to digit, flags bases outside the alphabet
   rke_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .radix      (cfg.radix),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // short queue so front and back stall independently
   rke_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // rolling index, read framing, remainder unit and result register
   rke_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: sim/kmer_index_checker.sv
`default_nettype none

module kmer_index_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rke_pkg::CHAR_W-1:0]     req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rke_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input  logic [rke_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rke_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rke_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [rke_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             kmers_owed
);
   import rke_pkg::*;

   localparam logic [3:0] NOT_BASE = 4'hF;

   typedef struct {
      logic [IDX_W-1:0] kmer;
      status_type       status;
   } kmer_word_type;

   kmer_word_type owed_words[$];

   // register copies
   logic [RADIX_W-1:0] radix;
   logic [KLEN_W-1:0]  klen;
   logic [TOP_W-1:0]   top_weight;

   // read state
   logic [IDX_W-1:0]   window;
   logic [KLEN_W-1:0]  seen;
   logic               dropped;

   int                 words_seen;

   initial fail_count = 0;

   function automatic logic [KLEN_W-1:0] span_of(input logic [KLEN_W-1:0] k);
      if (k == 0) return KLEN_W'(1);
      if (k > MAX_KMER) return KLEN_W'(MAX_KMER);
      return k;
   endfunction

   function automatic logic [TOP_W-1:0] weight_of(input logic [RADIX_W-1:0] r,
                                                  input logic [KLEN_W-1:0] k);
      logic [TOP_W-1:0] w;
      w = 1;
      for (int i = 1; i < span_of(k); i++)
         w = w * r;   // product kept to the weight width
      return w;
   endfunction

   function automatic logic [3:0] digit_of(input logic [CHAR_W-1:0] ch);
      case (ch)
         "A", "a":           return 4'd0;
         "C", "c":           return 4'd1;
         "G", "g":           return 4'd2;
         "T", "t", "U", "u": return 4'd3;
         "N", "n":           return 4'd4;
         default:            return NOT_BASE;
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic owe(input logic [IDX_W-1:0] kmer, input status_type st);
      kmer_word_type e;
      e.kmer   = kmer;
      e.status = st;
      owed_words.push_back(e);
   endtask

   task automatic clear_read();
      window  = '0;
      seen    = '0;
      dropped = 1'b0;
   endtask

   task automatic take_base(input logic [CHAR_W-1:0] ch, input logic first,
                            input logic is_last);
      logic [3:0]        d;
      longint unsigned   w;
      logic [KLEN_W-1:0] k;
      k = span_of(klen);
      if (first)
         clear_read();
      if (dropped) begin
         if (is_last)
            clear_read();
         return;
      end
      d = digit_of(ch);
      if (d == NOT_BASE || d >= radix) begin
         dropped = 1'b1;
         owe('0, STATUS_BAD_BASE);
         if (is_last)
            clear_read();
         return;
      end
      w = window;
      if (seen >= k) begin
         if (top_weight != 0)
            w = w % top_weight;
      end else begin
         seen++;
      end
      w = w * radix + d;
      window = w[IDX_W-1:0];
      if (seen >= k)
         owe(window, STATUS_OK);
      else if (is_last)
         owe('0, STATUS_SHORT);
      if (is_last)
         clear_read();
   endtask

   always @(posedge clock) begin
      kmer_word_type exp_word;
      csr_reg_type   reg_sel;
      if (reset) begin
         radix      = ALPHABET_RESET;
         klen       = KMER_RESET;
         top_weight = weight_of(radix, klen);
         clear_read();
         owed_words.delete();
         words_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (owed_words.size() == 0) begin
               note_mismatch($sformatf("result word %0d with nothing expected (data %0h)",
                                       words_seen, rsp_tdata));
            end else begin
               exp_word = owed_words.pop_front();
               if (rsp_tdata !== OUT_DATA_W'(exp_word.kmer))
                  note_mismatch($sformatf("word %0d kmer_index %0d, expected %0d",
                                          words_seen, rsp_tdata, exp_word.kmer));
               if (rsp_tuser !== exp_word.status)
                  note_mismatch($sformatf("word %0d status %0d, expected %0d",
                                          words_seen, rsp_tuser, exp_word.status));
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            reg_sel = csr_reg_type'(csr_paddr[2]);
            if (csr_pwrite) begin
               if (reg_sel == REG_ALPHABET)
                  radix = csr_pwdata[RADIX_W-1:0];
               else
                  klen = csr_pwdata[KLEN_W-1:0];
               top_weight = weight_of(radix, klen);
            end else if (reg_sel == REG_ALPHABET) begin
               if (csr_prdata !== CSR_DATA_W'(radix))
                  note_mismatch($sformatf("alphabet_size reads %0d, expected %0d",
                                          csr_prdata, radix));
            end else if (csr_prdata !== CSR_DATA_W'(klen)) begin
               note_mismatch($sformatf("kmer_length reads %0d, expected %0d",
                                       csr_prdata, klen));
            end
         end
         if (req_tvalid && req_tready)
            take_base(req_tdata, req_tuser, req_tlast);
      end
      kmers_owed = owed_words.size();
   end

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
   import rke_pkg::*;

   // worst run: ~450 words, each with a long send gap, a long result stall and
   // the remainder pass, several times over
   localparam int CYCLE_LIMIT = 400000;
   // result register path plus the remainder pass, with margin
   localparam int SETTLE      = 24;
   localparam int PHASE_WORDS = 20;
   localparam int FIXED_PHASES  = 10;
   localparam int RANDOM_PHASES = 6;

   // fixed register settings, extremes and out-of-range values among them
   localparam int PHASE_RADIX [FIXED_PHASES] = '{5, 1, 0, 7, 6, 2, 3, 5, 4, 5};
   localparam int PHASE_K     [FIXED_PHASES] = '{9, 1, 3, 15, 9, 0, 12, 1, 7, 10};

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    kmers_owed;

   // stimulus-side view of the current setting, only used to shape reads
   int                    cur_radix = 4;
   int                    cur_span  = 5;
   // stretches with no idling on either side
   bit                    steady_in  = 1'b0;
   bit                    steady_out = 1'b0;
   int                    hold_left  = 0;
   int                    cycle_count = 0;

   rolling_kmer_index_encoder dut (.*);

   kmer_index_checker kmer_watch (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= 1'b1;
         hold_left = idle_len(steady_out);
      end
   end

   // one spelling of a digit, upper or lower case, T or U for digit 3
   function automatic logic [CHAR_W-1:0] base_spelling(input int d);
      bit up;
      up = $urandom_range(0, 1);
      case (d)
         0: return up ? "A" : "a";
         1: return up ? "C" : "c";
         2: return up ? "G" : "g";
         3: case ($urandom_range(0, 3))
               0: return "T";
               1: return "t";
               2: return "U";
               default: return "u";
            endcase
         default: return up ? "N" : "n";
      endcase
   endfunction

   // a byte that the current alphabet rejects
   function automatic logic [CHAR_W-1:0] junk_char();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return {1'b1, 7'($urandom)};
         3: return "B";
         4: return "*";
         default: return (cur_radix < 5) ? base_spelling($urandom_range(cur_radix, 4))
                                         : "Z";
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] good_char();
      int lim;
      lim = (cur_radix > 5) ? 5 : cur_radix;
      if (lim == 0)
         return junk_char();
      return base_spelling($urandom_range(0, lim - 1));
   endfunction

   // one word on the base stream, held until the block takes it
   task automatic send_word(input logic [CHAR_W-1:0] ch, input logic first,
                            input logic is_last);
      int gap;
      gap = idle_len(steady_in);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
   endtask

   // setup then access cycle; reads are compared by the checker
   task automatic csr_access(input csr_reg_type sel, input logic wr,
                             input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'({sel, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // block idle: every expected word back, then room for words that make no result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (kmers_owed != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // a read: mostly well framed with valid bases, a few noisy or broken ones
   task automatic run_read(inout int sent);
      int               len;
      bit               noise;
      bit               framed_start;
      bit               framed_end;
      logic [CHAR_W-1:0] ch;
      logic             first;
      logic             is_last;
      noise        = ($urandom_range(0, 9) == 0);
      framed_start = ($urandom_range(0, 99) < 85);
      framed_end   = ($urandom_range(0, 99) < 80);
      if ($urandom_range(0, 9) < 7)
         len = $urandom_range(cur_span, cur_span + 8);
      else
         len = $urandom_range(1, cur_span);
      for (int i = 0; i < len; i++) begin
         if (noise) begin
            ch      = $urandom_range(0, 1) ? 8'($urandom) : good_char();
            first   = $urandom_range(0, 1);
            is_last = ($urandom_range(0, 3) == 0);
         end else begin
            ch      = ($urandom_range(0, 99) < 3) ? junk_char() : good_char();
            first   = (i == 0) && framed_start;
            is_last = (i == len - 1) && framed_end;
         end
         send_word(ch, first, is_last);
         sent++;
      end
   endtask

   initial begin
      int radix_val;
      int k_val;
      int sent;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset setting (radix 4, k 5)
      send_word("A", 1'b1, 1'b0);
      send_word("c", 1'b0, 1'b0);
      send_word("g", 1'b0, 1'b0);
      send_word("T", 1'b0, 1'b0);
      send_word("u", 1'b0, 1'b0);   // window full
      send_word("a", 1'b0, 1'b0);   // sliding
      send_word("n", 1'b0, 1'b0);   // N outside radix 4
      send_word("G", 1'b0, 1'b0);   // dropped read, ignored
      send_word("C", 1'b0, 1'b1);   // read end clears the drop
      send_word("T", 1'b1, 1'b1);   // one-base read, short
      send_word(8'h00, 1'b1, 1'b0); // lowest byte, invalid
      send_word(8'hFF, 1'b0, 1'b0); // ignored
      send_word("A", 1'b1, 1'b0);   // read start lifts the drop
      send_word("C", 1'b0, 1'b1);   // short read
      send_word("G", 1'b0, 1'b0);   // new read without a start mark
      send_word("G", 1'b0, 1'b0);
      send_word("t", 1'b0, 1'b0);
      send_word("T", 1'b0, 1'b0);
      send_word("U", 1'b0, 1'b0);
      send_word("g", 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1); // invalid on the last base of a read
      send_word("N", 1'b1, 1'b1);

      // register phases; reads may run on across a change
      for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
         wait_drained();
         if (p < FIXED_PHASES) begin
            radix_val = PHASE_RADIX[p];
            k_val     = PHASE_K[p];
         end else begin
            radix_val = $urandom_range(1, 5);
            k_val     = $urandom_range(1, 9);
         end
         // junk in the unused upper bits
         csr_access(REG_ALPHABET, 1'b1, ($urandom << RADIX_W) | radix_val);
         csr_access(REG_KMER, 1'b1, ($urandom << KLEN_W) | k_val);
         csr_access(REG_ALPHABET, 1'b0, '0);
         csr_access(REG_KMER, 1'b0, '0);
         cur_radix  = radix_val;
         cur_span   = (k_val == 0) ? 1 : (k_val > MAX_KMER) ? MAX_KMER : k_val;
         steady_in  = ($urandom_range(0, 3) == 0);
         steady_out = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_WORDS)
            run_read(sent);
      end

      wait_drained();
      @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
